// File: design/rwpa_pkg.sv
// Package for the rotated window pixel address generator.
// Holds widths, codes, reset values, shared types and helper functions.
// No dependencies.
`timescale 1ns / 1ps

package rwpa_pkg;

    // Largest logical side in pixels; coordinate fields are 11 bits wide
    localparam int MAX_SIDE   = 2048;
    localparam int COORD_W    = 11;
    localparam int SIDE_W     = 12;
    localparam int OFFSET_W   = 13;
    localparam int PIXEL_W    = 32;
    localparam int BYTES_W    = 3;
    localparam int ORIENT_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Request codes
    localparam logic REQ_SET_WINDOW = 1'b0;
    localparam logic REQ_PIXEL      = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ROTATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd4;

    // Register reset values
    localparam logic [SIDE_W-1:0]   RST_PANEL_WIDTH     = 12'd320;
    localparam logic [SIDE_W-1:0]   RST_PANEL_HEIGHT    = 12'd240;
    localparam logic [ORIENT_W-1:0] RST_ROTATION        = 3'd0;
    localparam logic [ORIENT_W-1:0] RST_OFFSET_ROTATION = 3'd0;
    localparam logic [BYTES_W-1:0]  RST_BYTES_PER_PIXEL = 3'd2;

    // Orientations whose row is mirrored: 1, 2, 4 and 7
    localparam logic [7:0] MIRROR_ROW_MASK = 8'b10010110;

    // Derived configuration seen by the datapath
    typedef struct packed {
        logic [ORIENT_W-1:0] orient;   // effective orientation
        logic [COORD_W-1:0]  wm1;      // logical width minus one
        logic [COORD_W-1:0]  hm1;      // logical height minus one
        logic [BYTES_W-1:0]  bytes;    // effective bytes per pixel, 1..4
        logic                reload;   // window/cursor go back to full area
    } cfg_t;

    // One result transaction
    typedef struct packed {
        logic [COORD_W-1:0]  line_row;
        logic [OFFSET_W-1:0] byte_offset;
        logic [PIXEL_W-1:0]  pixel_out;
        logic [BYTES_W-1:0]  byte_count;
    } res_t;

    // Side clamped to 1..MAX_SIDE, minus one
    function automatic logic [COORD_W-1:0] side_minus_one(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] s;
        begin
            if (v == '0)
                s = SIDE_W'(1);
            else if (v > SIDE_W'(MAX_SIDE))
                s = SIDE_W'(MAX_SIDE);
            else
                s = v;
            side_minus_one = COORD_W'(s - SIDE_W'(1));
        end
    endfunction

    // Rotation combined with panel mounting rotation
    function automatic logic [ORIENT_W-1:0] orientation(input logic [ORIENT_W-1:0] r,
                                                        input logic [ORIENT_W-1:0] o);
        logic [1:0] turns;
        begin
            turns = r[1:0] + o[1:0];
            orientation = {r[2] ^ o[2], turns};
        end
    endfunction

    // Bytes per pixel limited to 1..4
    function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] b);
        begin
            if (b == '0)
                eff_bytes = BYTES_W'(1);
            else if (b > BYTES_W'(4))
                eff_bytes = BYTES_W'(4);
            else
                eff_bytes = b;
        end
    endfunction

endpackage

// File: design/rwpa_cfg.sv
// Configuration registers and the derived orientation, logical size and byte count.
// Depends on rwpa_pkg.
`timescale 1ns / 1ps

module rwpa_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rwpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rwpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rwpa_pkg::cfg_t                     cfg_info
);

    logic [rwpa_pkg::SIDE_W-1:0]   panel_width_reg, panel_width_next;
    logic [rwpa_pkg::SIDE_W-1:0]   panel_height_reg, panel_height_next;
    logic [rwpa_pkg::ORIENT_W-1:0] rotation_reg, rotation_next;
    logic [rwpa_pkg::ORIENT_W-1:0] offset_rot_reg, offset_rot_next;
    logic [rwpa_pkg::BYTES_W-1:0]  bpp_reg, bpp_next;
    logic                          reload_next;
    logic [rwpa_pkg::ORIENT_W-1:0] orient_next;
    rwpa_pkg::cfg_t                info_reg, info_next;
    logic                          wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_comb
    begin
        panel_width_next  = panel_width_reg;
        panel_height_next = panel_height_reg;
        rotation_next     = rotation_reg;
        offset_rot_next   = offset_rot_reg;
        bpp_next          = bpp_reg;
        reload_next       = 1'b0;
        if (wr)
        begin
            case (cfg_index)
                rwpa_pkg::CFG_PANEL_WIDTH:
                begin
                    panel_width_next = cfg_data;
                    reload_next      = 1'b1;
                end
                rwpa_pkg::CFG_PANEL_HEIGHT:
                begin
                    panel_height_next = cfg_data;
                    reload_next       = 1'b1;
                end
                rwpa_pkg::CFG_ROTATION:
                begin
                    rotation_next = cfg_data[rwpa_pkg::ORIENT_W-1:0];
                    reload_next   = 1'b1;
                end
                rwpa_pkg::CFG_OFFSET_ROTATION:
                begin
                    offset_rot_next = cfg_data[rwpa_pkg::ORIENT_W-1:0];
                    reload_next     = 1'b1;
                end
                rwpa_pkg::CFG_BYTES_PER_PIXEL:
                begin
                    bpp_next = cfg_data[rwpa_pkg::BYTES_W-1:0];
                end
                default:
                begin
                    reload_next = 1'b0;
                end
            endcase
        end

        // odd orientations swap the logical axes
        orient_next      = rwpa_pkg::orientation(rotation_next, offset_rot_next);
        info_next.orient = orient_next;
        info_next.wm1    = orient_next[0] ? rwpa_pkg::side_minus_one(panel_height_next)
                                          : rwpa_pkg::side_minus_one(panel_width_next);
        info_next.hm1    = orient_next[0] ? rwpa_pkg::side_minus_one(panel_width_next)
                                          : rwpa_pkg::side_minus_one(panel_height_next);
        info_next.bytes  = rwpa_pkg::eff_bytes(bpp_next);
        info_next.reload = reload_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= rwpa_pkg::RST_PANEL_WIDTH;
            panel_height_reg <= rwpa_pkg::RST_PANEL_HEIGHT;
            rotation_reg     <= rwpa_pkg::RST_ROTATION;
            offset_rot_reg   <= rwpa_pkg::RST_OFFSET_ROTATION;
            bpp_reg          <= rwpa_pkg::RST_BYTES_PER_PIXEL;
            info_reg.orient  <= rwpa_pkg::orientation(rwpa_pkg::RST_ROTATION,
                                                      rwpa_pkg::RST_OFFSET_ROTATION);
            info_reg.wm1     <= rwpa_pkg::side_minus_one(rwpa_pkg::RST_PANEL_WIDTH);
            info_reg.hm1     <= rwpa_pkg::side_minus_one(rwpa_pkg::RST_PANEL_HEIGHT);
            info_reg.bytes   <= rwpa_pkg::eff_bytes(rwpa_pkg::RST_BYTES_PER_PIXEL);
            info_reg.reload  <= 1'b0;
        end
        else
        begin
            panel_width_reg  <= panel_width_next;
            panel_height_reg <= panel_height_next;
            rotation_reg     <= rotation_next;
            offset_rot_reg   <= offset_rot_next;
            bpp_reg          <= bpp_next;
            info_reg         <= info_next;
        end
    end

    assign cfg_info = info_reg;

endmodule

// File: design/rwpa_map.sv
// Maps a logical cursor position to a physical line row and byte offset,
// and masks the pixel to the stored byte count. Depends on rwpa_pkg.
`timescale 1ns / 1ps

module rwpa_map (
    input  rwpa_pkg::cfg_t                   cfg_info,
    input  logic [rwpa_pkg::COORD_W-1:0]     cursor_x,
    input  logic [rwpa_pkg::COORD_W-1:0]     cursor_y,
    input  logic [rwpa_pkg::PIXEL_W-1:0]     pixel,
    output rwpa_pkg::res_t                   res
);

    logic [rwpa_pkg::COORD_W-1:0]                    cx, cy, mx, my, px, py;
    logic [rwpa_pkg::COORD_W+rwpa_pkg::BYTES_W-1:0]  product;
    logic [rwpa_pkg::PIXEL_W-1:0]                    masked;

    always_comb
    begin
        cx = (cursor_x > cfg_info.wm1) ? cfg_info.wm1 : cursor_x;
        cy = (cursor_y > cfg_info.hm1) ? cfg_info.hm1 : cursor_y;
        my = rwpa_pkg::MIRROR_ROW_MASK[cfg_info.orient] ? (cfg_info.hm1 - cy) : cy;
        mx = cfg_info.orient[1] ? (cfg_info.wm1 - cx) : cx;
        // axis swap for odd orientations
        px = cfg_info.orient[0] ? my : mx;
        py = cfg_info.orient[0] ? mx : my;

        product = (rwpa_pkg::COORD_W + rwpa_pkg::BYTES_W)'(px) *
                  (rwpa_pkg::COORD_W + rwpa_pkg::BYTES_W)'(cfg_info.bytes);

        case (cfg_info.bytes)
            3'd1:    masked = {24'd0, pixel[7:0]};
            3'd2:    masked = {16'd0, pixel[15:0]};
            3'd3:    masked = {8'd0, pixel[23:0]};
            default: masked = pixel;
        endcase

        res.line_row    = py;
        res.byte_offset = product[rwpa_pkg::OFFSET_W-1:0];
        res.pixel_out   = masked;
        res.byte_count  = cfg_info.bytes;
    end

endmodule

// File: design/rotated_window_pixel_address_generator.sv
// Rotated window pixel address generator: top level.
// Depends on rwpa_pkg, rwpa_cfg and rwpa_map.
`timescale 1ns / 1ps

// Takes one transaction per clock on the input channel unless stalled and
// turns each pixel transaction into one write address (physical line row,
// byte offset) plus the masked pixel, via the input and result registers;
// set-window transactions update the window and cursor and produce no
// result. The sustained rate is one transaction per cycle unless stalled,
// set by the cursor update loop between the input register and the result
// register. The input side only stalls when a pixel sits in the input
// register and the result register is full and stalled. Configuration
// writes are taken every cycle (cfg_ready is tied high); a write of panel
// size or either rotation brings the window back to the full logical area
// and the cursor to 0,0. Configure only while the block is idle.

module rotated_window_pixel_address_generator (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [rwpa_pkg::COORD_W-1:0]       win_x_start,
    input  logic [rwpa_pkg::COORD_W-1:0]       win_y_start,
    input  logic [rwpa_pkg::COORD_W-1:0]       win_x_end,
    input  logic [rwpa_pkg::COORD_W-1:0]       win_y_end,
    input  logic [rwpa_pkg::PIXEL_W-1:0]       pixel,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rwpa_pkg::COORD_W-1:0]       line_row,
    output logic [rwpa_pkg::OFFSET_W-1:0]      byte_offset,
    output logic [rwpa_pkg::PIXEL_W-1:0]       pixel_out,
    output logic [rwpa_pkg::BYTES_W-1:0]       byte_count,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rwpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rwpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rwpa_pkg::cfg_t                   cfg_info;
    rwpa_pkg::res_t                   map_res;
    rwpa_pkg::res_t                   res_reg;

    // Input register
    logic                             s1_valid_reg, s1_valid_next;
    logic                             s1_type_reg;
    logic [rwpa_pkg::COORD_W-1:0]     s1_xs_reg, s1_ys_reg, s1_xe_reg, s1_ye_reg;
    logic [rwpa_pkg::PIXEL_W-1:0]     s1_pixel_reg;

    // Window and cursor
    logic [rwpa_pkg::COORD_W-1:0]     win_left_reg, win_left_next;
    logic [rwpa_pkg::COORD_W-1:0]     win_top_reg, win_top_next;
    logic [rwpa_pkg::COORD_W-1:0]     win_right_reg, win_right_next;
    logic [rwpa_pkg::COORD_W-1:0]     win_bottom_reg, win_bottom_next;
    logic [rwpa_pkg::COORD_W-1:0]     cursor_x_reg, cursor_x_next;
    logic [rwpa_pkg::COORD_W-1:0]     cursor_y_reg, cursor_y_next;

    logic                             out_valid_reg, out_valid_next;
    logic                             out_can_load, s1_fire, in_accept;

    rwpa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_info  (cfg_info)
    );

    rwpa_map u_map (
        .cfg_info (cfg_info),
        .cursor_x (cursor_x_reg),
        .cursor_y (cursor_y_reg),
        .pixel    (s1_pixel_reg),
        .res      (map_res)
    );

    // Handshake: a set-window transaction always leaves the input register;
    // a pixel leaves only when the result register can take it.
    assign out_can_load = !out_valid_reg || !out_stall;
    assign s1_fire      = s1_valid_reg &&
                          ((s1_type_reg == rwpa_pkg::REQ_SET_WINDOW) || out_can_load);
    assign in_stall     = s1_valid_reg && !s1_fire;
    assign in_accept    = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_can_load)
            out_valid_next = s1_fire && (s1_type_reg == rwpa_pkg::REQ_PIXEL);
    end

    // Window and cursor update
    always_comb
    begin
        win_left_next   = win_left_reg;
        win_top_next    = win_top_reg;
        win_right_next  = win_right_reg;
        win_bottom_next = win_bottom_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;

        if (cfg_info.reload)
        begin
            win_left_next   = '0;
            win_top_next    = '0;
            win_right_next  = cfg_info.wm1;
            win_bottom_next = cfg_info.hm1;
            cursor_x_next   = '0;
            cursor_y_next   = '0;
        end
        else if (s1_fire && (s1_type_reg == rwpa_pkg::REQ_SET_WINDOW))
        begin
            // corners clamped to the logical size; inverted windows kept
            win_left_next   = (s1_xs_reg > cfg_info.wm1) ? cfg_info.wm1 : s1_xs_reg;
            win_top_next    = (s1_ys_reg > cfg_info.hm1) ? cfg_info.hm1 : s1_ys_reg;
            win_right_next  = (s1_xe_reg > cfg_info.wm1) ? cfg_info.wm1 : s1_xe_reg;
            win_bottom_next = (s1_ye_reg > cfg_info.hm1) ? cfg_info.hm1 : s1_ye_reg;
            cursor_x_next   = win_left_next;
            cursor_y_next   = win_top_next;
        end
        else if (s1_fire)
        begin
            // step right, wrap to the next line, wrap to the window top
            if (cursor_x_reg >= win_right_reg)
            begin
                cursor_x_next = win_left_reg;
                cursor_y_next = (cursor_y_reg >= win_bottom_reg) ? win_top_reg
                                                                 : cursor_y_reg + 1'b1;
            end
            else
            begin
                cursor_x_next = cursor_x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            win_left_reg   <= '0;
            win_top_reg    <= '0;
            win_right_reg  <= rwpa_pkg::side_minus_one(rwpa_pkg::RST_PANEL_WIDTH);
            win_bottom_reg <= rwpa_pkg::side_minus_one(rwpa_pkg::RST_PANEL_HEIGHT);
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            win_left_reg   <= win_left_next;
            win_top_reg    <= win_top_next;
            win_right_reg  <= win_right_next;
            win_bottom_reg <= win_bottom_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_type_reg  <= req_type;
            s1_xs_reg    <= win_x_start;
            s1_ys_reg    <= win_y_start;
            s1_xe_reg    <= win_x_end;
            s1_ye_reg    <= win_y_end;
            s1_pixel_reg <= pixel;
        end
        if (out_can_load && s1_fire && (s1_type_reg == rwpa_pkg::REQ_PIXEL))
            res_reg <= map_res;
    end

    assign out_valid   = out_valid_reg;
    assign line_row    = res_reg.line_row;
    assign byte_offset = res_reg.byte_offset;
    assign pixel_out   = res_reg.pixel_out;
    assign byte_count  = res_reg.byte_count;

    // Cursor never leaves the logical area (except the cycle before a reload)
    a_cursor_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_info.reload |-> cursor_x_reg <= cfg_info.wm1)
        else $error("cursor_x beyond logical width");

    a_cursor_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_info.reload |-> cursor_y_reg <= cfg_info.hm1)
        else $error("cursor_y beyond logical height");

    // A set-window transaction produces no result
    a_set_window_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_type_reg == rwpa_pkg::REQ_SET_WINDOW) && out_can_load)
        |=> !out_valid_reg)
        else $error("set-window transaction produced a result");

    // Input stalls only behind a held pixel
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && (s1_type_reg == rwpa_pkg::REQ_PIXEL)
                      && out_valid_reg && out_stall))
        else $error("input stalled without a blocked pixel");

endmodule
